// ----- rtl/pqc_pkg.sv -----
// pqc_pkg: shared types and constants for the max priority queue core
// no dependencies; imported by pqc_cell and max_heap_priority_queue_core
package pqc_pkg;

   localparam int KEY_W        = 32;
   localparam int COUNT_OUT_W  = 6;
   localparam int DEF_CAPACITY = 32;

   // operation selector carried in req_tuser
   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   // result status carried in rsp_tuser
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // one stored key with its occupancy flag
   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
   } slot_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

// ----- rtl/max_heap_priority_queue_core.sv -----
// max_heap_priority_queue_core: max priority queue as a sorted systolic chain of cells
// depends on pqc_pkg and pqc_cell
//
//   channel  dir  tdata                              tuser
//   req_     in   key_in[31:0]                       func (0 insert, 1 delete max)
//   rsp_     out  key_out[31:0], count_out[37:32]    status (0 ok, 1 full, 2 empty)
//
// on an insert all cells compare against the new key in parallel and shift by
// one place, a delete shifts them back, so the chain stays sorted largest first.
// the result sits in an output register; a new request is taken whenever that
// register is empty or being drained in the same cycle.
// reset clears the key count, the response valid flag and all cell occupancy flags.
module max_heap_priority_queue_core #(
   parameter int CAPACITY = pqc_pkg::DEF_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key_in[31:0]
   input  logic [0:0]  req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // key_out[31:0], count_out[37:32], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import pqc_pkg::*;

   localparam int CountW = $clog2(CAPACITY + 1);

   logic                    accept;
   logic                    is_full;
   logic                    is_empty;
   cell_ctrl_type           ctrl;
   slot_type                chain [CAPACITY];
   logic                    place [CAPACITY];
   logic [CountW-1:0]       count_ff;
   logic [CountW-1:0]       count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [KEY_W-1:0] rsp_key_ff;
   logic signed [KEY_W-1:0] rsp_key_in;
   status_type              rsp_status_ff;
   status_type              rsp_status_in;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff;
   logic [COUNT_OUT_W-1:0]  rsp_count_in;

   // handshake and capacity checks
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CountW'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   // command for the chain
   always_comb begin
      ctrl.insert = accept && (op_type'(req_tuser) == OP_INSERT) && !is_full;
      ctrl.remove = accept && (op_type'(req_tuser) == OP_DELETE) && !is_empty;
   end

   // row of cells, cell 0 holds the maximum
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      slot_type left_s;
      slot_type right_s;
      logic     left_p;
      if (i == 0) begin : g_head
         assign left_s = '0;
         assign left_p = 1'b0;
      end else begin : g_body
         assign left_s = chain[i-1];
         assign left_p = place[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_s = '0;
      end else begin : g_inner
         assign right_s = chain[i+1];
      end
      pqc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_key    (req_tdata),
         .left_slot  (left_s),
         .left_place (left_p),
         .right_slot (right_s),
         .slot       (chain[i]),
         .place      (place[i])
      );
   end

   // next count and result
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CountW'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CountW'(1);
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = '0;
         rsp_status_in = ST_OK;
         if (op_type'(req_tuser) == OP_INSERT) begin
            if (is_full) rsp_status_in = ST_FULL;
         end else begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_key_in = chain[0].key;
            end
         end
      end
      rsp_count_in = accept ? COUNT_OUT_W'(count_in) : rsp_count_ff;
   end

   // count and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- rtl/pqc_cell.sv -----
// pqc_cell: one slot of the sorted key chain (largest key at cell 0)
// depends on pqc_pkg for slot_type and cell_ctrl_type
module pqc_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  pqc_pkg::cell_ctrl_type             ctrl,
   input  logic signed [pqc_pkg::KEY_W-1:0]   new_key,
   input  pqc_pkg::slot_type                  left_slot,
   input  logic                               left_place,
   input  pqc_pkg::slot_type                  right_slot,
   output pqc_pkg::slot_type                  slot,
   output logic                               place
);
   import pqc_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   // new key belongs at or before this cell: empty or strictly smaller key here
   assign place = !slot_ff.valid || (new_key > slot_ff.key);
   assign slot  = slot_ff;

   // insert shifts right from the insertion point, delete shifts left
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.insert) begin
         if (left_place) begin
            slot_in = left_slot;
         end else if (place) begin
            slot_in.valid = 1'b1;
            slot_in.key   = new_key;
         end
      end else if (ctrl.remove) begin
         slot_in = right_slot;
      end
   end

   // occupancy cleared by reset, key payload left as is
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule
